>>> sv/icdf_pkg.sv
`default_nettype none
package icdf_pkg;

	// shared long divider geometry
	localparam int DIV_NUM_W = 64;
	localparam int DIV_DEN_W = 32;
	localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

	// configuration register indexes
	localparam logic [2:0] REG_POINT_COUNT = 3'd0;
	localparam logic [2:0] REG_RESOLUTION  = 3'd1;
	localparam logic [2:0] REG_DOMAIN_MIN  = 3'd2;
	localparam logic [2:0] REG_DOMAIN_MAX  = 3'd3;
	localparam logic [2:0] REG_MIN_ENERGY  = 3'd4;

	localparam int POINT_COUNT_W = 7;
	localparam int RESOLUTION_W  = 5;
	localparam int MIN_ENERGY_W  = 8;

	typedef struct packed {
		logic                 start;
		logic [DIV_NUM_W-1:0] dividend;
		logic [DIV_DEN_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic                 done;
		logic [DIV_NUM_W-1:0] quotient;
	} div_rsp_t;

endpackage
`default_nettype wire

>>> sv/icdf_div.sv
`default_nettype none
// Restoring unsigned divider, one quotient bit per cycle.
module icdf_div (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire icdf_pkg::div_req_t req,
	output icdf_pkg::div_rsp_t   rsp
);

	logic                           busy_q;
	logic                           done_q;
	logic [icdf_pkg::DIV_CNT_W-1:0] step_q;
	logic [icdf_pkg::DIV_NUM_W-1:0] quo_q;
	logic [icdf_pkg::DIV_DEN_W-1:0] rem_q;
	logic [icdf_pkg::DIV_DEN_W-1:0] den_q;
	logic [icdf_pkg::DIV_DEN_W:0]   rem_sh;
	logic                           fits;

	assign rem_sh = {rem_q, quo_q[icdf_pkg::DIV_NUM_W-1]};
	assign fits   = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == icdf_pkg::DIV_CNT_W'(icdf_pkg::DIV_NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			den_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[icdf_pkg::DIV_NUM_W-2:0], fits};
			if (fits) begin
				rem_q <= icdf_pkg::DIV_DEN_W'(rem_sh - {1'b0, den_q});
			end else begin
				rem_q <= rem_sh[icdf_pkg::DIV_DEN_W-1:0];
			end
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule
`default_nettype wire

>>> sv/inverse_cdf_point_placer.sv
// Loading: one sample per cycle into the cumulative store, no result; s_tready drops after the last.
// Placement: a setup step, eps padding of the missing entries, a read of the total,
// a ramp rewrite of the table when energy is missing, then the divide for the level step.
// Per point: a walk of the table entries, reads of the bracketing entries, a fraction
// divide, a bit-serial multiply, a scale divide, then the output, held until m_tready.
// Store (one write, one read port) and bit-serial divider are shared; reset clears control, loads defaults.
`default_nettype none
module inverse_cdf_point_placer #(
	parameter int MAX_POINTS     = 64,
	parameter int MAX_RESOLUTION = 16,
	parameter int STORE_DEPTH    = 1026
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [15:0] s_tdata,   // energy_sample[15:0]
	input  wire         s_tlast,   // last_sample
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [31:0] m_tdata,   // position[31:0]
	output logic        m_tlast,   // last_point
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [2:0]  cfg_index,
	input  wire  [31:0] cfg_data
);

	localparam int AW  = $clog2(STORE_DEPTH);
	localparam int XQW = AW + 17;
	localparam int PW  = 2 * icdf_pkg::POINT_COUNT_W;

	typedef enum logic [19:0] {
		ST_IDLE     = 20'h00001,
		ST_SETUP    = 20'h00002,
		ST_FILL     = 20'h00004,
		ST_TOT_RD   = 20'h00008,
		ST_TOT_CAP  = 20'h00010,
		ST_RAMP     = 20'h00020,
		ST_DSTART   = 20'h00040,
		ST_DELTA    = 20'h00080,
		ST_WALK_RD  = 20'h00100,
		ST_WALK_CMP = 20'h00200,
		ST_LO_RD    = 20'h00400,
		ST_LO_CAP   = 20'h00800,
		ST_HI_CAP   = 20'h01000,
		ST_FSTART   = 20'h02000,
		ST_FRAC     = 20'h04000,
		ST_MUL      = 20'h08000,
		ST_SSTART   = 20'h10000,
		ST_SCALE    = 20'h20000,
		ST_OUT      = 20'h40000
	} state_t;

	state_t state_q;

	// configuration
	logic [icdf_pkg::POINT_COUNT_W-1:0] point_count_q;
	logic [icdf_pkg::RESOLUTION_W-1:0]  resolution_q;
	logic [31:0]                        domain_min_q;
	logic [31:0]                        domain_max_q;
	logic [icdf_pkg::MIN_ENERGY_W-1:0]  min_energy_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_count_q <= icdf_pkg::POINT_COUNT_W'(2);
			resolution_q  <= icdf_pkg::RESOLUTION_W'(1);
			domain_min_q  <= 32'd0;
			domain_max_q  <= 32'd65536;
			min_energy_q  <= icdf_pkg::MIN_ENERGY_W'(1);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				icdf_pkg::REG_POINT_COUNT: point_count_q <= cfg_data[icdf_pkg::POINT_COUNT_W-1:0];
				icdf_pkg::REG_RESOLUTION:  resolution_q  <= cfg_data[icdf_pkg::RESOLUTION_W-1:0];
				icdf_pkg::REG_DOMAIN_MIN:  domain_min_q  <= cfg_data;
				icdf_pkg::REG_DOMAIN_MAX:  domain_max_q  <= cfg_data;
				icdf_pkg::REG_MIN_ENERGY:  min_energy_q  <= cfg_data[icdf_pkg::MIN_ENERGY_W-1:0];
				default: ;
			endcase
		end
	end

	// effective settings
	logic [7:0]  eps;
	logic [31:0] eps32;
	logic [6:0]  n_eff;
	logic [6:0]  res_eff;
	logic [PW-1:0] cnt_raw;
	logic [AW-1:0] cnt_eff;

	assign eps     = (min_energy_q == '0) ? 8'd1 : min_energy_q;
	assign eps32   = {24'd0, eps};
	assign n_eff   = (point_count_q < 7'd2) ? 7'd2 :
		(point_count_q > 7'(MAX_POINTS)) ? 7'(MAX_POINTS) : point_count_q;
	assign res_eff = (resolution_q == '0) ? 7'd1 :
		({2'b0, resolution_q} > 7'(MAX_RESOLUTION)) ? 7'(MAX_RESOLUTION) : {2'b0, resolution_q};
	assign cnt_raw = PW'(n_eff) * PW'(res_eff);
	assign cnt_eff = (32'(cnt_raw) > 32'(STORE_DEPTH - 2)) ? AW'(STORE_DEPTH - 2) : AW'(cnt_raw);

	// run state
	logic [AW-1:0]   ctr_q;
	logic [31:0]     rsum_q;
	logic [6:0]      n_q;
	logic [AW-1:0]   cnt_q;
	logic [7:0]      eps_q;
	logic [AW:0]     fill_idx_q;
	logic [31:0]     fill_sum_q;
	logic [31:0]     total_q;
	logic [31:0]     delta_q;
	logic [AW-1:0]   walk_q;
	logic [31:0]     level_q;
	logic [6:0]      point_q;
	logic [31:0]     lo_q;
	logic [31:0]     hi_q;
	logic [63:0]     acc_q;
	logic [63:0]     mcand_q;
	logic [XQW-1:0]  mplier_q;
	logic [$clog2(XQW)-1:0] mstep_q;
	logic            m_tvalid_q;
	logic [31:0]     m_tdata_q;
	logic            m_tlast_q;

	// cumulative store
	logic [31:0]   mem [STORE_DEPTH];
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [31:0]   mem_wdata;
	logic [AW-1:0] mem_raddr;
	logic [31:0]   rdata_q;
	logic          rzero_q;
	logic [31:0]   rd;

	logic          s_acc;
	logic          room;
	logic [31:0]   add32;
	logic [AW:0]   cnt_p1;

	assign s_tready = (state_q == ST_IDLE);
	assign s_acc    = s_tvalid && s_tready;
	assign room     = (32'(ctr_q) + 32'd1) < 32'(STORE_DEPTH);
	assign add32    = ($signed(s_tdata) > $signed({8'd0, eps})) ? {16'd0, s_tdata} : eps32;
	assign cnt_p1   = {1'b0, cnt_q} + 1'b1;
	assign rd       = rzero_q ? 32'd0 : rdata_q;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = AW'(ctr_q + 1'b1);
		mem_wdata = rsum_q + add32;
		mem_raddr = '0;
		unique case (state_q)
			ST_IDLE: mem_we = s_acc && room;
			ST_FILL: begin
				mem_we    = (fill_idx_q <= cnt_p1);
				mem_waddr = fill_idx_q[AW-1:0];
				mem_wdata = fill_sum_q + {24'd0, eps_q};
			end
			ST_RAMP: begin
				mem_we    = (fill_idx_q <= cnt_p1);
				mem_waddr = fill_idx_q[AW-1:0];
				mem_wdata = 32'(fill_idx_q) << 8;
			end
			ST_TOT_RD:  mem_raddr = cnt_q;
			ST_WALK_RD: mem_raddr = walk_q;
			ST_LO_RD:   mem_raddr = walk_q - 1'b1;
			ST_LO_CAP:  mem_raddr = walk_q;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rdata_q <= mem[mem_raddr];
		rzero_q <= (mem_raddr == '0);
	end

	// divider
	icdf_pkg::div_req_t div_req;
	icdf_pkg::div_rsp_t div_rsp;
	logic [31:0] f_num;
	logic [31:0] d_den;

	assign f_num = (level_q > lo_q) ? level_q - lo_q : 32'd0;
	assign d_den = (hi_q > lo_q) ? hi_q - lo_q : 32'd1;

	always_comb begin
		div_req.start    = 1'b0;
		div_req.dividend = acc_q;
		div_req.divisor  = 32'(cnt_q) << 16;
		unique case (state_q)
			ST_DSTART: begin
				div_req.start    = 1'b1;
				div_req.dividend = 64'(total_q - {24'd0, eps_q});
				div_req.divisor  = 32'(n_q - 7'd1);
			end
			ST_FSTART: begin
				div_req.start    = 1'b1;
				div_req.dividend = {16'd0, f_num, 16'd0};
				div_req.divisor  = d_den;
			end
			ST_SSTART: div_req.start = 1'b1;
			default: ;
		endcase
	end

	icdf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// scaling arithmetic
	logic [32:0] dx;
	logic        dx_neg;
	logic [32:0] dx_mag;
	logic [47:0] frac;
	logic [XQW-1:0] xq;
	logic [36:0] sq;
	logic [36:0] pos37;
	logic [31:0] pos_sat;

	assign dx     = {domain_max_q[31], domain_max_q} - {domain_min_q[31], domain_min_q};
	assign dx_neg = dx[32];
	assign dx_mag = dx_neg ? 33'(-dx) : dx;
	assign frac   = (div_rsp.quotient[47:0] > 48'd65536) ? 48'd65536 : div_rsp.quotient[47:0];
	assign xq     = (XQW'(walk_q - 1'b1) << 16) + XQW'(frac[16:0]);
	assign sq     = dx_neg ? 37'(-{2'b0, div_rsp.quotient[34:0]}) : {2'b0, div_rsp.quotient[34:0]};
	assign pos37  = {{5{domain_min_q[31]}}, domain_min_q} + sq;
	assign pos_sat = ($signed(pos37) > $signed(37'sh07FFFFFFF)) ? 32'h7FFFFFFF :
		($signed(pos37) < -$signed(37'sh080000000)) ? 32'h80000000 : pos37[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			ctr_q      <= '0;
			rsum_q     <= '0;
			walk_q     <= '0;
			level_q    <= '0;
			point_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_acc) begin
						if (room) begin
							rsum_q <= rsum_q + add32;
							ctr_q  <= ctr_q + 1'b1;
						end
						if (s_tlast) begin
							state_q <= ST_SETUP;
						end
					end
				end
				ST_SETUP: begin
					n_q        <= n_eff;
					cnt_q      <= cnt_eff;
					eps_q      <= eps;
					fill_idx_q <= {1'b0, ctr_q} + 1'b1;
					fill_sum_q <= rsum_q;
					state_q    <= ST_FILL;
				end
				ST_FILL: begin
					if (fill_idx_q <= cnt_p1) begin
						fill_sum_q <= fill_sum_q + {24'd0, eps_q};
						fill_idx_q <= fill_idx_q + 1'b1;
					end else begin
						state_q <= ST_TOT_RD;
					end
				end
				ST_TOT_RD: state_q <= ST_TOT_CAP;
				ST_TOT_CAP: begin
					if (rd < {24'd0, eps_q}) begin
						// no usable energy: uniform ramp
						total_q    <= 32'(cnt_q) << 8;
						fill_idx_q <= (AW+1)'(1);
						state_q    <= ST_RAMP;
					end else begin
						total_q <= rd;
						state_q <= ST_DSTART;
					end
				end
				ST_RAMP: begin
					if (fill_idx_q <= cnt_p1) begin
						fill_idx_q <= fill_idx_q + 1'b1;
					end else begin
						state_q <= ST_DSTART;
					end
				end
				ST_DSTART: state_q <= ST_DELTA;
				ST_DELTA: begin
					if (div_rsp.done) begin
						delta_q <= div_rsp.quotient[31:0];
						// entry zero is zero, so the first step always passes it
						walk_q  <= AW'(1);
						level_q <= '0;
						point_q <= '0;
						state_q <= ST_WALK_RD;
					end
				end
				ST_WALK_RD: begin
					state_q <= ({1'b0, walk_q} < cnt_p1) ? ST_WALK_CMP : ST_LO_RD;
				end
				ST_WALK_CMP: begin
					if (level_q >= rd) begin
						walk_q  <= walk_q + 1'b1;
						state_q <= ST_WALK_RD;
					end else begin
						state_q <= ST_LO_RD;
					end
				end
				ST_LO_RD: state_q <= ST_LO_CAP;
				ST_LO_CAP: begin
					lo_q    <= rd;
					state_q <= ST_HI_CAP;
				end
				ST_HI_CAP: begin
					hi_q    <= rd;
					state_q <= ST_FSTART;
				end
				ST_FSTART: state_q <= ST_FRAC;
				ST_FRAC: begin
					if (div_rsp.done) begin
						acc_q    <= '0;
						mcand_q  <= 64'(dx_mag);
						mplier_q <= xq;
						mstep_q  <= '0;
						state_q  <= ST_MUL;
					end
				end
				ST_MUL: begin
					if (mplier_q[0]) begin
						acc_q <= acc_q + mcand_q;
					end
					mcand_q  <= mcand_q << 1;
					mplier_q <= mplier_q >> 1;
					mstep_q  <= mstep_q + 1'b1;
					if (mstep_q == ($clog2(XQW))'(XQW - 1)) begin
						state_q <= ST_SSTART;
					end
				end
				ST_SSTART: state_q <= ST_SCALE;
				ST_SCALE: begin
					if (div_rsp.done) begin
						m_tdata_q  <= pos_sat;
						m_tlast_q  <= (point_q == n_q - 7'd1);
						m_tvalid_q <= 1'b1;
						state_q    <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (m_tready) begin
						m_tvalid_q <= 1'b0;
						if (m_tlast_q) begin
							ctr_q   <= '0;
							rsum_q  <= '0;
							walk_q  <= '0;
							level_q <= '0;
							point_q <= '0;
							state_q <= ST_IDLE;
						end else begin
							level_q <= level_q + delta_q;
							point_q <= point_q + 1'b1;
							state_q <= ST_WALK_RD;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input accepted while a point is pending");

	a_no_entry0_write: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> mem_waddr != '0)
		else $error("entry zero of the cumulative store written");

	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK_CMP) |-> ({1'b0, walk_q} < cnt_p1))
		else $error("walk ran past the table end");

	a_run_ends_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && m_tlast) |=> s_tready && ctr_q == '0)
		else $error("block not idle after the final point");

endmodule
`default_nettype wire

>>> dv/inverse_cdf_point_placer_tb.sv
`default_nettype none
module inverse_cdf_point_placer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_POINTS     = 64;
	localparam int MAX_RESOLUTION = 16;
	localparam int STORE_DEPTH    = 1026;
	localparam int CYCLE_LIMIT    = 3000000;

	typedef struct packed {
		logic [15:0] energy;
		logic        last;
	} sample_t;

	typedef struct packed {
		logic [31:0] position;
		logic        last;
	} point_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;
	logic        m_tlast;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_data;

	inverse_cdf_point_placer #(
		.MAX_POINTS(MAX_POINTS),
		.MAX_RESOLUTION(MAX_RESOLUTION),
		.STORE_DEPTH(STORE_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// predictor state
	logic [6:0]  cur_points;
	logic [4:0]  cur_res;
	logic [31:0] cur_dmin;
	logic [31:0] cur_dmax;
	logic [7:0]  cur_min_energy;
	logic [31:0] cum_table [STORE_DEPTH];
	int unsigned samples_loaded;
	logic [31:0] energy_sum;

	sample_t     pending_samples[$];
	point_t      expected_points[$];
	int          send_idle_pct;
	int          recv_stall_pct;
	int          errors;
	longint      cycles;
	logic        s_fire;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic void model_reset();
		cur_points     = 7'd2;
		cur_res        = 5'd1;
		cur_dmin       = 32'd0;
		cur_dmax       = 32'd65536;
		cur_min_energy = 8'd1;
		for (int i = 0; i < STORE_DEPTH; i++)
			cum_table[i] = '0;
		samples_loaded = 0;
		energy_sum     = '0;
	endfunction

	// accumulate one sample; on the last one compute every placed point
	function automatic void place_points(sample_t s);
		logic [31:0] eps;
		int          e;
		logic [31:0] add;
		int unsigned n, res, cnt, idx;
		logic [31:0] total, delta, level, lo, hi, d, f;
		longint      dmin, dx, denom, pos;
		logic [63:0] frac, xq;

		eps = (cur_min_energy == 0) ? 32'd1 : {24'd0, cur_min_energy};
		e   = $signed(s.energy);
		add = (e > int'(eps)) ? 32'(e) : eps;
		if (samples_loaded + 1 < STORE_DEPTH) begin
			energy_sum += add;
			samples_loaded++;
			cum_table[samples_loaded] = energy_sum;
		end
		if (!s.last)
			return;

		n   = cur_points < 2 ? 2 : (cur_points > MAX_POINTS ? MAX_POINTS : cur_points);
		res = cur_res < 1 ? 1 : (cur_res > MAX_RESOLUTION ? MAX_RESOLUTION : cur_res);
		cnt = n * res;
		if (cnt > STORE_DEPTH - 2)
			cnt = STORE_DEPTH - 2;

		cum_table[0] = '0;
		for (int unsigned i = samples_loaded + 1; i <= cnt + 1; i++)
			cum_table[i] = cum_table[i-1] + eps;
		total = cum_table[cnt];
		// no real energy: fall back to a uniform ramp
		if (total < eps) begin
			for (int unsigned i = 1; i <= cnt + 1; i++)
				cum_table[i] = i << 8;
			total = cum_table[cnt];
		end
		delta = (total - eps) / (n - 1);

		dmin  = longint'($signed(cur_dmin));
		dx    = longint'($signed(cur_dmax)) - dmin;
		denom = longint'(cnt) << 16;

		idx   = 0;
		level = '0;
		for (int unsigned p = 0; p < n; p++) begin
			while (idx < cnt + 1 && level >= cum_table[idx])
				idx++;
			if (idx == 0)
				idx = 1;
			lo   = cum_table[idx-1];
			hi   = cum_table[idx];
			d    = hi > lo ? hi - lo : 32'd1;
			f    = level > lo ? level - lo : 32'd0;
			frac = ({32'd0, f} << 16) / {32'd0, d};
			if (frac > 64'd65536)
				frac = 64'd65536;
			xq  = (64'(idx - 1) << 16) + frac;
			pos = dmin + (dx * longint'(xq)) / denom;
			if (pos > 64'sd2147483647)
				pos = 64'sd2147483647;
			if (pos < -64'sd2147483648)
				pos = -64'sd2147483648;
			expected_points.push_back('{position: pos[31:0], last: (p == n - 1)});
			level += delta;
		end
		samples_loaded = 0;
		energy_sum     = '0;
	endfunction

	// handshake flag sampled at the rising edge and consumed by the driver
	always @(posedge clk)
		s_fire <= s_tvalid && s_tready;

	// driver
	always @(negedge clk) begin
		if (s_fire) begin
			place_points(pending_samples.pop_front());
		end
		if (arst_n && pending_samples.size() != 0
				&& ((s_tvalid && !s_fire) || $urandom_range(99) >= send_idle_pct)) begin
			s_tvalid <= 1'b1;
			s_tdata  <= pending_samples[0].energy;
			s_tlast  <= pending_samples[0].last;
		end else begin
			s_tvalid <= 1'b0;
		end
		m_tready <= arst_n && ($urandom_range(99) >= recv_stall_pct);
	end

	// monitor
	always @(posedge clk) begin
		point_t exp_pt;
		cycles++;
		if (m_tvalid && m_tready) begin
			if (expected_points.size() == 0) begin
				$display("%0t: unexpected point, expected none, actual position %h last %b",
					$time, m_tdata, m_tlast);
				errors++;
			end else begin
				exp_pt = expected_points.pop_front();
				if (m_tdata !== exp_pt.position) begin
					$display("%0t: position mismatch, expected %h actual %h",
						$time, exp_pt.position, m_tdata);
					errors++;
				end
				if (m_tlast !== exp_pt.last) begin
					$display("%0t: last_point mismatch, expected %b actual %b",
						$time, exp_pt.last, m_tlast);
					errors++;
				end
			end
		end
		if (cycles > CYCLE_LIMIT) begin
			$display("[inverse_cdf_point_placer] ERROR");
			$finish;
		end
	end

	task automatic write_reg(input logic [2:0] index, input logic [31:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		case (index)
			icdf_pkg::REG_POINT_COUNT: cur_points     = value[6:0];
			icdf_pkg::REG_RESOLUTION:  cur_res        = value[4:0];
			icdf_pkg::REG_DOMAIN_MIN:  cur_dmin       = value;
			icdf_pkg::REG_DOMAIN_MAX:  cur_dmax       = value;
			icdf_pkg::REG_MIN_ENERGY:  cur_min_energy = value[7:0];
			default: ;
		endcase
	endtask

	task automatic drain();
		while (pending_samples.size() != 0 || s_tvalid || expected_points.size() != 0)
			@(posedge clk);
		// loading-only samples leave no result; let the block settle
		repeat (200) @(posedge clk);
	endtask

	task automatic configure(input int pts, input int res, input logic [31:0] lo,
			input logic [31:0] hi, input int eps);
		write_reg(icdf_pkg::REG_POINT_COUNT, pts);
		write_reg(icdf_pkg::REG_RESOLUTION, res);
		write_reg(icdf_pkg::REG_DOMAIN_MIN, lo);
		write_reg(icdf_pkg::REG_DOMAIN_MAX, hi);
		write_reg(icdf_pkg::REG_MIN_ENERGY, eps);
	endtask

	// one run: count samples with random energy, last marked
	task automatic queue_run(input int count, input int style);
		logic [15:0] en;
		for (int i = 0; i < count; i++) begin
			case (style)
				0: en = 16'($urandom);
				1: en = 16'($urandom_range(0, 2047));
				2: en = 16'h8000 | 16'($urandom);
				default: en = ($urandom_range(3) == 0) ? 16'h7FFF : 16'($urandom_range(511));
			endcase
			pending_samples.push_back('{energy: en, last: (i == count - 1)});
		end
	endtask

	function automatic int run_len(input int pts, input int res);
		int cnt;
		int r;
		cnt = pts * res;
		r   = $urandom_range(9);
		if (r == 0)
			return $urandom_range(1, cnt);
		if (r == 1)
			return cnt + 1 + $urandom_range(3);
		return cnt + 1;
	endfunction

	initial begin
		int pts, res, eps;
		errors         = 0;
		cycles         = 0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		arst_n         = 1'b0;
		s_tvalid       = 1'b0;
		s_tdata        = '0;
		s_tlast        = 1'b0;
		m_tready       = 1'b0;
		cfg_valid      = 1'b0;
		cfg_index      = '0;
		cfg_data       = '0;
		model_reset();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// defaults: two points over [0,1]
		pending_samples.push_back('{energy: 16'h0100, last: 1'b0});
		pending_samples.push_back('{energy: 16'h0200, last: 1'b0});
		pending_samples.push_back('{energy: 16'h7FFF, last: 1'b1});
		// negative energy only, every entry takes the eps floor
		pending_samples.push_back('{energy: 16'h8000, last: 1'b1});
		drain();

		configure(3, 2, 32'h8000_0000, 32'h7FFF_FFFF, 255);
		pending_samples.push_back('{energy: 16'h8000, last: 1'b0});
		pending_samples.push_back('{energy: 16'h0000, last: 1'b0});
		pending_samples.push_back('{energy: 16'h7FFF, last: 1'b0});
		pending_samples.push_back('{energy: 16'hFFFF, last: 1'b0});
		pending_samples.push_back('{energy: 16'h00FF, last: 1'b0});
		pending_samples.push_back('{energy: 16'h0100, last: 1'b0});
		pending_samples.push_back('{energy: 16'h5555, last: 1'b0});
		pending_samples.push_back('{energy: 16'h2AAA, last: 1'b1});
		drain();

		// out-of-range registers, reversed domain, zero eps
		configure(0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 0);
		pending_samples.push_back('{energy: 16'h0000, last: 1'b1});
		pending_samples.push_back('{energy: 16'h1234, last: 1'b0});
		pending_samples.push_back('{energy: 16'hFEDC, last: 1'b1});
		drain();
		configure(127, 31, 32'hFFFF_0000, 32'h0001_0000, 1);
		queue_run(2, 1);
		drain();

		for (int phase = 0; phase < 8; phase++) begin
			case (phase % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
				default: begin send_idle_pct = 26; recv_stall_pct = 26; end
			endcase
			pts = (phase == 7) ? 64 : ((phase == 6) ? 2 : $urandom_range(2, 4));
			res = (phase == 6) ? 16 : $urandom_range(1, 2);
			eps = (phase == 5) ? 255 : $urandom_range(1, 255);
			configure(pts, res, $urandom, $urandom, eps);
			if (phase == 7)
				queue_run(8, 0);
			else
				for (int k = 0; k < 3; k++)
					queue_run(run_len(pts, res), $urandom_range(3));
			drain();
		end

		if (errors == 0)
			$display("[inverse_cdf_point_placer] OK");
		else
			$display("[inverse_cdf_point_placer] ERROR");
		$finish;
	end
endmodule
`default_nettype wire

>>> sim.f
sv/icdf_pkg.sv
sv/icdf_div.sv
sv/inverse_cdf_point_placer.sv
dv/inverse_cdf_point_placer_tb.sv
